>>> src/slt_pkg.sv
// Shared types and constants for the script language tokenizer.
package slt_pkg;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_source;
    } t_in;

    typedef struct packed {
        logic [5:0]  token_code;
        logic [23:0] start_line;
        logic [15:0] start_column;
        logic [31:0] start_offset;
        logic [15:0] span_length;
        logic [7:0]  bad_char;
        logic        last_of_run;
    } t_out;

    // Token kinds
    localparam logic [5:0] K_DOT        = 6'd13;
    localparam logic [5:0] K_EQUAL      = 6'd14;
    localparam logic [5:0] K_BANG       = 6'd15;
    localparam logic [5:0] K_GREATER    = 6'd16;
    localparam logic [5:0] K_LESS       = 6'd17;
    localparam logic [5:0] K_DOTDOT     = 6'd18;
    localparam logic [5:0] K_IDENT      = 6'd39;
    localparam logic [5:0] K_NUMBER     = 6'd40;
    localparam logic [5:0] K_STRING     = 6'd41;
    localparam logic [5:0] K_ERR_STRING = 6'd42;
    localparam logic [5:0] K_ERR_CHAR   = 6'd43;
    localparam logic [5:0] K_EOF        = 6'd44;

    // Character class codes from the front end
    typedef enum logic [3:0] {
        C_BLANK, C_NEWLINE, C_HASH, C_QUOTE, C_DIGIT, C_ALPHA,
        C_SINGLE, C_DOT, C_OPER, C_OTHER
    } t_cls;

    // Classified transaction passed from front to back
    typedef struct packed {
        logic [7:0] ch;
        logic       eos;
        t_cls       cls;
        logic [5:0] single_kind;
    } t_tok_in;

    function automatic logic [5:0] single_code(input logic [7:0] c);
        logic [5:0] k;
        k = 6'd0;
        unique case (c)
            8'h2B: k = 6'd0;  8'h2D: k = 6'd1;  8'h2A: k = 6'd2;
            8'h2F: k = 6'd3;  8'h25: k = 6'd4;  8'h28: k = 6'd5;
            8'h29: k = 6'd6;  8'h7B: k = 6'd7;  8'h7D: k = 6'd8;
            8'h2C: k = 6'd9;  8'h3F: k = 6'd10; 8'h3A: k = 6'd11;
            8'h3B: k = 6'd12;
            default: k = 6'd0;
        endcase
        return k;
    endfunction

    function automatic logic [5:0] op_kind(input logic [7:0] p);
        logic [5:0] k;
        k = K_LESS;
        unique case (p)
            8'h2E: k = K_DOT;
            8'h3D: k = K_EQUAL;
            8'h21: k = K_BANG;
            8'h3E: k = K_GREATER;
            default: k = K_LESS;
        endcase
        return k;
    endfunction

    function automatic logic [5:0] kw_kind(input logic [2:0] len, input logic [47:0] p);
        logic [5:0] k;
        k = K_IDENT;
        unique case ({len, p})
            {3'd3, 48'h00000064_6E61}: k = 6'd23;
            {3'd5, 48'h0073_7361_6C63}: k = 6'd24;
            {3'd4, 48'h0000_6573_6C65}: k = 6'd25;
            {3'd5, 48'h0065_736C_6166}: k = 6'd26;
            {3'd3, 48'h0000_0072_6F66}: k = 6'd27;
            {3'd3, 48'h0000_006E_7566}: k = 6'd28;
            {3'd2, 48'h0000_0000_6669}: k = 6'd29;
            {3'd3, 48'h0000_006C_696E}: k = 6'd30;
            {3'd2, 48'h0000_0000_726F}: k = 6'd31;
            {3'd5, 48'h0074_6E69_7270}: k = 6'd32;
            {3'd6, 48'h6E72_7574_6572}: k = 6'd33;
            {3'd5, 48'h0072_6570_7573}: k = 6'd34;
            {3'd4, 48'h0000_7369_6874}: k = 6'd35;
            {3'd4, 48'h0000_6575_7274}: k = 6'd36;
            {3'd3, 48'h0000_0072_6176}: k = 6'd37;
            {3'd5, 48'h0065_6C69_6877}: k = 6'd38;
            default: k = K_IDENT;
        endcase
        return k;
    endfunction

endpackage

>>> src/slt_front.sv
// Front end: accepts source bytes, classifies them, feeds a two-entry queue.
module slt_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  slt_pkg::t_in   i_data,
    output logic           o_q_valid,
    input  logic           i_q_take,
    output slt_pkg::t_tok_in o_q_data
);
    import slt_pkg::*;

    t_tok_in   r_q [2];
    logic      r_rd, r_wr;
    logic [1:0] r_cnt;
    t_tok_in   w_cls;
    logic      w_push, w_pop;

    // Classify the incoming byte
    always_comb begin
        logic [7:0] c;
        c = i_data.char_code;
        w_cls.ch  = c;
        w_cls.eos = i_data.end_of_source;
        w_cls.single_kind = single_code(c);
        if (c == 8'h20 || c == 8'h09 || c == 8'h0B || c == 8'h0C || c == 8'h0D)
            w_cls.cls = C_BLANK;
        else if (c == 8'h0A) w_cls.cls = C_NEWLINE;
        else if (c == 8'h23) w_cls.cls = C_HASH;
        else if (c == 8'h22) w_cls.cls = C_QUOTE;
        else if (c >= 8'h30 && c <= 8'h39) w_cls.cls = C_DIGIT;
        else if ((c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == 8'h5F)
            w_cls.cls = C_ALPHA;
        else if (c == 8'h2B || c == 8'h2D || c == 8'h2A || c == 8'h2F || c == 8'h25 ||
                 c == 8'h28 || c == 8'h29 || c == 8'h7B || c == 8'h7D || c == 8'h2C ||
                 c == 8'h3F || c == 8'h3A || c == 8'h3B)
            w_cls.cls = C_SINGLE;
        else if (c == 8'h2E) w_cls.cls = C_DOT;
        else if (c == 8'h3D || c == 8'h21 || c == 8'h3E || c == 8'h3C) w_cls.cls = C_OPER;
        else w_cls.cls = C_OTHER;
    end

    assign o_stall   = (r_cnt == 2'd2);
    assign w_push    = i_valid && !o_stall;
    assign o_q_valid = (r_cnt != 2'd0);
    assign w_pop     = o_q_valid && i_q_take;
    assign o_q_data  = r_q[r_rd];

    // Advance queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd <= 1'b0;
            r_wr <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wr <= !r_wr;
            if (w_pop) r_rd <= !r_rd;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wr] <= w_cls;
    end
endmodule

>>> src/slt_back.sv
// Back end: scanner state machine, emits up to three tokens per byte.
module slt_back #(
    parameter int LINE_BITS   = 24,
    parameter int COLUMN_BITS = 16,
    parameter int LENGTH_BITS = 16,
    parameter int OFFSET_BITS = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    output logic             o_q_take,
    input  slt_pkg::t_tok_in i_q_data,
    output logic             o_valid,
    input  logic             i_stall,
    output slt_pkg::t_out    o_data
);
    import slt_pkg::*;

    typedef enum logic [7:0] {
        M_IDLE    = 8'b00000001, M_COMMENT = 8'b00000010,
        M_IDENT   = 8'b00000100, M_INT     = 8'b00001000,
        M_DOT     = 8'b00010000, M_FRAC    = 8'b00100000,
        M_STRING  = 8'b01000000, M_OPER    = 8'b10000000
    } t_mode;

    localparam logic [LINE_BITS-1:0]   LMAX = '1;
    localparam logic [COLUMN_BITS-1:0] CMAX = '1;
    localparam logic [LENGTH_BITS-1:0] NMAX = '1;

    typedef struct packed {
        logic [5:0]             kind;
        logic [LINE_BITS-1:0]   line;
        logic [COLUMN_BITS-1:0] col;
        logic [OFFSET_BITS-1:0] off;
        logic [LENGTH_BITS-1:0] len;
        logic [7:0]             bad;
    } t_tok;

    t_mode r_mode, n_mode;
    logic [7:0] r_pend, n_pend;
    logic [LINE_BITS-1:0] r_line, n_line, r_sl, n_sl;
    logic [COLUMN_BITS-1:0] r_col, n_col, r_sc, n_sc;
    logic [OFFSET_BITS-1:0] r_pos, n_pos, r_so, n_so;
    logic [LENGTH_BITS-1:0] r_len, n_len;
    logic [47:0] r_pfx, n_pfx;

    t_tok r_tk [3];
    t_tok n_tk [3];
    logic [1:0] r_cnt, n_cnt, r_idx;
    logic w_go;

    // Emit pulls the snapshot of the current token registers
    always_comb begin
        t_mode m;
        logic [7:0] c;
        t_cls cl;
        logic done;
        logic [LENGTH_BITS-1:0] ln;
        n_mode = r_mode; n_pend = r_pend; n_line = r_line; n_col = r_col;
        n_pos = r_pos; n_sl = r_sl; n_sc = r_sc; n_so = r_so; n_len = r_len;
        n_pfx = r_pfx; n_cnt = 2'd0;
        for (int k = 0; k < 3; k++) n_tk[k] = '0;
        c = i_q_data.ch;
        cl = i_q_data.cls;
        m = r_mode;
        done = 1'b0;
        ln = r_len;
        if (i_q_data.eos) begin
            unique case (r_mode)
                M_IDENT: begin
                    n_tk[0] = '{(r_len <= LENGTH_BITS'(6)) ? kw_kind(r_len[2:0], r_pfx)
                               : K_IDENT, r_sl, r_sc, r_so, r_len, 8'd0};
                    n_cnt = 2'd1;
                end
                M_INT, M_FRAC: begin
                    n_tk[0] = '{K_NUMBER, r_sl, r_sc, r_so, r_len, 8'd0};
                    n_cnt = 2'd1;
                end
                M_DOT: begin
                    n_tk[0] = '{K_NUMBER, r_sl, r_sc, r_so, r_len, 8'd0};
                    n_tk[1] = '{K_DOT, r_line, r_col, r_pos, LENGTH_BITS'(1), 8'd0};
                    n_pos = r_pos + 1'b1;
                    n_col = (r_col == CMAX) ? CMAX : r_col + 1'b1;
                    n_cnt = 2'd2;
                end
                M_STRING: begin
                    n_tk[0] = '{K_ERR_STRING, r_sl, r_sc, r_so, r_len, 8'd0};
                    n_cnt = 2'd1;
                end
                M_OPER: begin
                    n_tk[0] = '{op_kind(r_pend), r_sl, r_sc, r_so, r_len, 8'd0};
                    n_cnt = 2'd1;
                end
                default: n_cnt = 2'd0;
            endcase
            n_tk[n_cnt] = '{K_EOF, r_line, n_col, n_pos, LENGTH_BITS'(3), 8'd0};
            n_cnt = n_cnt + 2'd1;
            n_mode = M_IDLE; n_pend = '0; n_line = LINE_BITS'(1); n_col = COLUMN_BITS'(1);
            n_pos = '0; n_sl = LINE_BITS'(1); n_sc = COLUMN_BITS'(1); n_so = '0;
            n_len = '0; n_pfx = '0;
        end else begin
            // Pending-token close, then re-feed (split dot, operator, idle: three passes)
            for (int pass = 0; pass < 3; pass++) begin
                if (!done) begin
                    unique case (m)
                        M_COMMENT: begin
                            if (cl == C_NEWLINE) m = M_IDLE;
                            else begin
                                n_pos = n_pos + 1'b1;
                                n_col = (n_col == CMAX) ? CMAX : n_col + 1'b1;
                                done = 1'b1;
                            end
                        end
                        M_IDENT: begin
                            if (cl == C_DIGIT || cl == C_ALPHA) begin
                                if (ln < LENGTH_BITS'(6))
                                    n_pfx = n_pfx | (48'(c) << {ln[2:0], 3'b000});
                                ln = (ln == NMAX) ? NMAX : ln + 1'b1;
                                n_pos = n_pos + 1'b1;
                                n_col = (n_col == CMAX) ? CMAX : n_col + 1'b1;
                                done = 1'b1;
                            end else begin
                                n_tk[n_cnt] = '{(ln <= LENGTH_BITS'(6))
                                    ? kw_kind(ln[2:0], n_pfx) : K_IDENT,
                                    n_sl, n_sc, n_so, ln, 8'd0};
                                n_cnt = n_cnt + 2'd1;
                                m = M_IDLE;
                            end
                        end
                        M_INT, M_FRAC: begin
                            if (cl == C_DIGIT) begin
                                ln = (ln == NMAX) ? NMAX : ln + 1'b1;
                                n_pos = n_pos + 1'b1;
                                n_col = (n_col == CMAX) ? CMAX : n_col + 1'b1;
                                done = 1'b1;
                            end else if (m == M_INT && cl == C_DOT) begin
                                m = M_DOT;
                                done = 1'b1;
                            end else begin
                                n_tk[n_cnt] = '{K_NUMBER, n_sl, n_sc, n_so, ln, 8'd0};
                                n_cnt = n_cnt + 2'd1;
                                m = M_IDLE;
                            end
                        end
                        M_DOT: begin
                            if (cl == C_DIGIT) begin
                                ln = (ln == NMAX) ? NMAX : ln + 1'b1;
                                ln = (ln == NMAX) ? NMAX : ln + 1'b1;
                                n_pos = n_pos + 2'd2;
                                n_col = (n_col == CMAX) ? CMAX : n_col + 1'b1;
                                n_col = (n_col == CMAX) ? CMAX : n_col + 1'b1;
                                m = M_FRAC;
                                done = 1'b1;
                            end else begin
                                n_tk[n_cnt] = '{K_NUMBER, n_sl, n_sc, n_so, ln, 8'd0};
                                n_cnt = n_cnt + 2'd1;
                                n_sl = n_line; n_sc = n_col; n_so = n_pos;
                                ln = LENGTH_BITS'(1);
                                n_pos = n_pos + 1'b1;
                                n_col = (n_col == CMAX) ? CMAX : n_col + 1'b1;
                                n_pend = 8'h2E;
                                m = M_OPER;
                            end
                        end
                        M_STRING: begin
                            ln = (ln == NMAX) ? NMAX : ln + 1'b1;
                            n_pos = n_pos + 1'b1;
                            if (cl == C_QUOTE) begin
                                n_col = (n_col == CMAX) ? CMAX : n_col + 1'b1;
                                n_tk[n_cnt] = '{K_STRING, n_sl, n_sc, n_so, ln, 8'd0};
                                n_cnt = n_cnt + 2'd1;
                                m = M_IDLE;
                            end else if (cl == C_NEWLINE) begin
                                n_col = COLUMN_BITS'(1);
                                n_line = (n_line == LMAX) ? LMAX : n_line + 1'b1;
                                n_tk[n_cnt] = '{K_ERR_STRING, n_sl, n_sc, n_so, ln, 8'd0};
                                n_cnt = n_cnt + 2'd1;
                                m = M_IDLE;
                            end else begin
                                n_col = (n_col == CMAX) ? CMAX : n_col + 1'b1;
                            end
                            done = 1'b1;
                        end
                        M_OPER: begin
                            if ((n_pend == 8'h2E && cl == C_DOT) ||
                                (n_pend != 8'h2E && c == 8'h3D)) begin
                                ln = (ln == NMAX) ? NMAX : ln + 1'b1;
                                n_pos = n_pos + 1'b1;
                                n_col = (n_col == CMAX) ? CMAX : n_col + 1'b1;
                                n_tk[n_cnt] = '{(n_pend == 8'h2E) ? K_DOTDOT
                                    : op_kind(n_pend) + 6'd5, n_sl, n_sc, n_so, ln, 8'd0};
                                n_cnt = n_cnt + 2'd1;
                                m = M_IDLE;
                                done = 1'b1;
                            end else begin
                                n_tk[n_cnt] = '{op_kind(n_pend), n_sl, n_sc, n_so, ln, 8'd0};
                                n_cnt = n_cnt + 2'd1;
                                m = M_IDLE;
                            end
                        end
                        default: begin
                            m = M_IDLE;
                            done = 1'b1;
                            if (cl == C_NEWLINE) begin
                                n_pos = n_pos + 1'b1;
                                n_col = COLUMN_BITS'(1);
                                n_line = (n_line == LMAX) ? LMAX : n_line + 1'b1;
                            end else begin
                                if (cl != C_BLANK && cl != C_HASH) begin
                                    n_sl = n_line; n_sc = n_col; n_so = n_pos;
                                    ln = LENGTH_BITS'(1);
                                end
                                n_pos = n_pos + 1'b1;
                                n_col = (n_col == CMAX) ? CMAX : n_col + 1'b1;
                                unique case (cl)
                                    C_HASH:   m = M_COMMENT;
                                    C_QUOTE:  m = M_STRING;
                                    C_DIGIT:  m = M_INT;
                                    C_ALPHA: begin
                                        n_pfx = {40'd0, c};
                                        m = M_IDENT;
                                    end
                                    C_SINGLE: begin
                                        n_tk[n_cnt] = '{i_q_data.single_kind, n_sl, n_sc,
                                                        n_so, ln, 8'd0};
                                        n_cnt = n_cnt + 2'd1;
                                    end
                                    C_DOT, C_OPER: begin
                                        n_pend = c;
                                        m = M_OPER;
                                    end
                                    C_OTHER: begin
                                        n_tk[n_cnt] = '{K_ERR_CHAR, n_sl, n_sc, n_so, ln, c};
                                        n_cnt = n_cnt + 2'd1;
                                    end
                                    default: m = M_IDLE;
                                endcase
                            end
                        end
                    endcase
                end
            end
            n_mode = m;
            n_len = ln;
        end
    end

    // Take a new byte once the previous run has drained or drains now
    assign o_valid  = (r_cnt != 2'd0);
    assign w_go     = !o_valid || (!i_stall && (r_idx == r_cnt - 2'd1));
    assign o_q_take = w_go;

    always_comb begin
        t_tok t;
        t = r_tk[r_idx];
        o_data.token_code    = t.kind;
        o_data.start_line    = 24'(t.line);
        o_data.start_column  = 16'(t.col);
        o_data.start_offset  = 32'(t.off);
        o_data.span_length   = 16'(t.len);
        o_data.bad_char      = t.bad;
        o_data.last_of_run   = (r_idx == r_cnt - 2'd1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE; r_pend <= '0; r_line <= LINE_BITS'(1);
            r_col <= COLUMN_BITS'(1); r_pos <= '0; r_sl <= LINE_BITS'(1);
            r_sc <= COLUMN_BITS'(1); r_so <= '0; r_len <= '0; r_pfx <= '0;
            r_cnt <= 2'd0; r_idx <= 2'd0;
        end else if (w_go) begin
            r_idx <= 2'd0;
            if (i_q_valid) begin
                r_mode <= n_mode; r_pend <= n_pend; r_line <= n_line; r_col <= n_col;
                r_pos <= n_pos; r_sl <= n_sl; r_sc <= n_sc; r_so <= n_so;
                r_len <= n_len; r_pfx <= n_pfx;
                r_cnt <= n_cnt;
            end else begin
                r_cnt <= 2'd0;
            end
        end else if (o_valid && !i_stall) begin
            r_idx <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go && i_q_valid) begin
            for (int k = 0; k < 3; k++) r_tk[k] <= n_tk[k];
        end
    end
endmodule

>>> src/script_language_tokenizer.sv
// Tokenizer: byte queue front end feeding a scanner back end with token buffer.
// Throughput: one byte per cycle while each byte yields at most one token and the output
// is not stalled; a byte yielding several tokens emits them in turn, the queue holds later bytes.
// Reset: synchronous active low; line and column 1, offset 0, queue empty.
module script_language_tokenizer #(
    parameter int LINE_BITS   = 24,
    parameter int COLUMN_BITS = 16,
    parameter int LENGTH_BITS = 16,
    parameter int OFFSET_BITS = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  slt_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_stall,
    output slt_pkg::t_out o_data
);
    import slt_pkg::*;

    logic    w_q_valid, w_q_take;
    t_tok_in w_q_data;

    slt_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_data,
        .o_q_valid(w_q_valid), .i_q_take(w_q_take), .o_q_data(w_q_data)
    );

    slt_back #(
        .LINE_BITS(LINE_BITS), .COLUMN_BITS(COLUMN_BITS),
        .LENGTH_BITS(LENGTH_BITS), .OFFSET_BITS(OFFSET_BITS)
    ) u_back (
        .i_clk, .i_rst_n,
        .i_q_valid(w_q_valid), .o_q_take(w_q_take), .i_q_data(w_q_data),
        .o_valid, .i_stall, .o_data
    );
endmodule
